FILE: sv/fli_pkg.sv
// Shared constants, types and helpers for the free list index mapper.
`timescale 1ns / 1ps
package fli_pkg;

	localparam int PHYS_DEPTH = 256;
	localparam int VIRT_DEPTH = 1024;
	localparam int PHYS_W     = $clog2(PHYS_DEPTH);
	localparam int VIRT_W     = $clog2(VIRT_DEPTH);
	localparam int LEVEL_W    = PHYS_W + 1;
	localparam int VCNT_W     = VIRT_W + 1;
	localparam int CFG_W      = VCNT_W;

	// request types
	localparam logic [1:0] REQ_OPEN   = 2'd0;
	localparam logic [1:0] REQ_CLOSE  = 2'd1;
	localparam logic [1:0] REQ_LOOKUP = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_RANGE    = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_UNMAPPED = 2'd3;

	// configuration register indexes
	localparam logic CFG_REAL = 1'b0;
	localparam logic CFG_VIRT = 1'b1;

	typedef struct packed {
		logic              valid;
		logic [PHYS_W-1:0] phys;
	} map_entry_t;

	localparam int MAP_W = $bits(map_entry_t);

	typedef struct packed {
		logic              en;
		logic [VIRT_W-1:0] addr;
		map_entry_t        data;
	} map_wr_t;

	typedef struct packed {
		logic              pop;
		logic              push;
		logic [PHYS_W-1:0] push_data;
	} fl_ctrl_t;

	function automatic logic [LEVEL_W-1:0] sat_real(input logic [LEVEL_W-1:0] v);
		sat_real = (v > LEVEL_W'(PHYS_DEPTH)) ? LEVEL_W'(PHYS_DEPTH) : v;
	endfunction

	function automatic logic [VCNT_W-1:0] sat_virt(input logic [VCNT_W-1:0] v);
		sat_virt = (v > VCNT_W'(VIRT_DEPTH)) ? VCNT_W'(VIRT_DEPTH) : v;
	endfunction

endpackage

FILE: sv/fli_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fli_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/fli_free_list.sv
// FIFO free list of physical indices held in a RAM with per-slot valid bits.
`timescale 1ns / 1ps
module fli_free_list import fli_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               init,
	input  logic [LEVEL_W-1:0] init_real,
	input  logic               rd_en,
	input  fl_ctrl_t           ctrl,
	output logic [PHYS_W-1:0]  head_data,
	output logic               empty
);

	logic [PHYS_W-1:0]     head_q;
	logic [PHYS_W-1:0]     tail_q;
	logic [LEVEL_W-1:0]    level_q;
	logic [PHYS_DEPTH-1:0] slot_vld_q;
	logic                  head_vld_q;
	logic [PHYS_W-1:0]     head_idx_q;
	logic [PHYS_W-1:0]     ram_rdata;
	logic                  push_ok;

	// drop a push onto a full list
	assign push_ok = ctrl.push && (level_q != LEVEL_W'(PHYS_DEPTH));
	assign empty   = (level_q == '0);

	// advance pointers and level, track written slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			level_q    <= LEVEL_W'(PHYS_DEPTH);
			slot_vld_q <= '0;
		end else if (init) begin
			head_q     <= '0;
			tail_q     <= init_real[PHYS_W-1:0];
			level_q    <= init_real;
			slot_vld_q <= '0;
		end else begin
			if (ctrl.pop) begin
				head_q  <= head_q + 1'b1;
				level_q <= level_q - 1'b1;
			end
			if (push_ok) begin
				tail_q             <= tail_q + 1'b1;
				level_q            <= level_q + 1'b1;
				slot_vld_q[tail_q] <= 1'b1;
			end
		end
	end

	// capture head slot state alongside the RAM read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			head_vld_q <= slot_vld_q[head_q];
			head_idx_q <= head_q;
		end
	end

	// an unwritten slot holds its own index
	assign head_data = head_vld_q ? ram_rdata : head_idx_q;

	fli_ram #(
		.WIDTH(PHYS_W),
		.DEPTH(PHYS_DEPTH)
	) u_queue_ram (
		.clk  (clk),
		.we   (push_ok),
		.waddr(tail_q),
		.wdata(ctrl.push_data),
		.re   (rd_en),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

endmodule

FILE: sv/fli_map.sv
// Map table RAM with a clearing pass after reset and reinitialization.
`timescale 1ns / 1ps
module fli_map import fli_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              init,
	input  logic              rd_en,
	input  logic [VIRT_W-1:0] rd_addr,
	input  map_wr_t           wr,
	output map_entry_t        rd_data,
	output logic              busy
);

	logic              clear_q;
	logic [VIRT_W-1:0] clr_addr_q;
	logic              ram_we;
	logic [VIRT_W-1:0] ram_waddr;
	map_entry_t        ram_wdata;
	logic [MAP_W-1:0]  ram_rdata;

	// sweep every entry to unmapped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q    <= 1'b1;
			clr_addr_q <= '0;
		end else if (init) begin
			clear_q    <= 1'b1;
			clr_addr_q <= '0;
		end else if (clear_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == VIRT_W'(VIRT_DEPTH - 1)) begin
				clear_q <= 1'b0;
			end
		end
	end

	assign busy      = clear_q;
	assign ram_we    = clear_q || wr.en;
	assign ram_waddr = clear_q ? clr_addr_q : wr.addr;
	assign ram_wdata = clear_q ? map_entry_t'('0) : wr.data;
	assign rd_data   = map_entry_t'(ram_rdata);

	fli_ram #(
		.WIDTH(MAP_W),
		.DEPTH(VIRT_DEPTH)
	) u_map_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

endmodule

FILE: sv/free_list_index_mapper.sv
// On acceptance the request is registered and its table and queue entries are read
// into the RAM read registers; the result is registered once the output is free or taken.
// A new request is not taken until the result of the previous one has been registered.
// Reset and each configuration write start a clearing pass over all 1024 map RAM entries;
// no request is taken until it completes. Control registers reset asynchronously.
`timescale 1ns / 1ps
module free_list_index_mapper import fli_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [VIRT_W-1:0]  virt_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PHYS_W-1:0]  phys_index,
	output logic               is_mapped,
	output logic [1:0]         status
);

	logic [LEVEL_W-1:0] real_count_q;
	logic [VCNT_W-1:0]  virt_count_q;
	logic               busy_q;
	logic [1:0]         req_q;
	logic [VIRT_W-1:0]  vidx_q;
	logic               out_valid_q;
	logic [PHYS_W-1:0]  phys_q;
	logic               mapped_q;
	logic [1:0]         status_q;

	logic               accept;
	logic               commit;
	logic               map_busy;
	logic [LEVEL_W-1:0] init_real;
	logic [VCNT_W-1:0]  eff_virt;
	map_entry_t         entry;
	logic [PHYS_W-1:0]  head_data;
	logic               fl_empty;
	fl_ctrl_t           fl_ctrl;
	map_wr_t            map_wr;
	logic [PHYS_W-1:0]  res_phys;
	logic               res_mapped;
	logic [1:0]         res_status;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			real_count_q <= LEVEL_W'(PHYS_DEPTH);
			virt_count_q <= VCNT_W'(VIRT_DEPTH);
		end else if (cfg_we) begin
			if (cfg_index == CFG_REAL) begin
				real_count_q <= cfg_data[LEVEL_W-1:0];
			end else begin
				virt_count_q <= cfg_data;
			end
		end
	end

	// pick the pool size the reinitialization uses
	assign init_real = (cfg_index == CFG_REAL) ? sat_real(cfg_data[LEVEL_W-1:0])
	                                           : sat_real(real_count_q);
	assign eff_virt  = sat_virt(virt_count_q);

	assign in_ready  = !busy_q && !map_busy;
	assign accept    = in_valid && in_ready;
	assign commit    = busy_q && (!out_valid_q || out_ready);

	// hold the request while its entries are read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (commit) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req_type;
			vidx_q <= virt_index;
		end
	end

	// decide the result and the state updates
	always_comb begin
		res_phys          = '0;
		res_mapped        = 1'b0;
		res_status        = ST_OK;
		fl_ctrl.pop       = 1'b0;
		fl_ctrl.push      = 1'b0;
		fl_ctrl.push_data = entry.phys;
		map_wr.en         = 1'b0;
		map_wr.addr       = vidx_q;
		map_wr.data       = '0;
		priority if ({1'b0, vidx_q} >= eff_virt) begin
			res_status = ST_RANGE;
		end else begin
			unique case (req_q)
				REQ_OPEN: begin
					if (fl_empty) begin
						res_status = ST_EMPTY;
					end else begin
						res_phys         = head_data;
						res_mapped       = 1'b1;
						fl_ctrl.pop      = commit;
						map_wr.en        = commit;
						map_wr.data.valid = 1'b1;
						map_wr.data.phys = head_data;
					end
				end
				REQ_CLOSE: begin
					if (!entry.valid) begin
						res_status = ST_UNMAPPED;
					end else begin
						res_phys     = entry.phys;
						fl_ctrl.push = commit;
						map_wr.en    = commit;
					end
				end
				default: begin
					if (entry.valid) begin
						res_phys   = entry.phys;
						res_mapped = 1'b1;
					end
				end
			endcase
		end
	end

	// hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			phys_q   <= res_phys;
			mapped_q <= res_mapped;
			status_q <= res_status;
		end
	end

	assign out_valid  = out_valid_q;
	assign phys_index = phys_q;
	assign is_mapped  = mapped_q;
	assign status     = status_q;

	fli_map u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.init   (cfg_we),
		.rd_en  (accept),
		.rd_addr(virt_index),
		.wr     (map_wr),
		.rd_data(entry),
		.busy   (map_busy)
	);

	fli_free_list u_free_list (
		.clk      (clk),
		.arst_n   (arst_n),
		.init     (cfg_we),
		.init_real(init_real),
		.rd_en    (accept),
		.ctrl     (fl_ctrl),
		.head_data(head_data),
		.empty    (fl_empty)
	);

endmodule
